>>> rtl/ipv6p_pkg.sv
// Package for the IPv6 text address parser: widths, character codes,
// hex digit decode and the parse summary struct. No dependencies.
`default_nettype none

package ipv6p_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned NibW      = 4;
  localparam int unsigned GroupW    = 16;
  localparam int unsigned NumGroups = 8;
  localparam int unsigned IdxW      = $clog2(NumGroups);
  localparam int unsigned CountW    = IdxW + 1;
  localparam int unsigned DigitW    = 3;
  localparam int unsigned HalfW     = GroupW * NumGroups / 2;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowA  = 8'h61;
  localparam logic [CharW-1:0] ChLowF  = 8'h66;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpF   = 8'h46;
  localparam logic [CharW-1:0] ChColon = 8'h3A;

  localparam logic [DigitW-1:0] DigitMax = '1;
  localparam logic [NibW-1:0]   NibTen   = 4'd10;

  typedef logic [GroupW-1:0] group_t;

  typedef struct packed {
    logic            ok;
    logic [NibW-1:0] nib;
  } hex_t;

  // State after the current character, as seen by the result builder
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [CountW-1:0] split;
    logic              compressed;
    logic              error;
  } parse_sum_t;

  function automatic hex_t hex_decode(input logic [CharW-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = '0;
    if (c inside {[ChZero:ChNine]}) begin
      h.nib = NibW'(c - ChZero);
    end else if (c inside {[ChLowA:ChLowF]}) begin
      h.nib = NibW'(c - ChLowA) + NibTen;
    end else if (c inside {[ChUpA:ChUpF]}) begin
      h.nib = NibW'(c - ChUpA) + NibTen;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ipv6p_if.sv
// Stream interfaces of the IPv6 text address parser: character in, address out.
// Depends on ipv6p_pkg.
`default_nettype none

interface ipv6p_char_if
  import ipv6p_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ipv6p_addr_if
  import ipv6p_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [HalfW-1:0] addr_high;
  logic [HalfW-1:0] addr_low;
  logic             malformed;

  modport source (output valid, output addr_high, output addr_low, output malformed,
                  input ready);
  modport sink   (input valid, input addr_high, input addr_low, input malformed,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/ipv6_text_address_parser.sv
// IPv6 text address parser, top level.
// A character accepted into the input register is parsed from there; for the last
// character the address is then loaded into the result register.
// Throughput: one character per cycle, but a final character stalls while the result register is full.
// Reset (rst_ni low, asynchronous) empties both registers and clears parse state.
`default_nettype none

module ipv6_text_address_parser
  import ipv6p_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ipv6p_char_if.sink     in_if,
  ipv6p_addr_if.source   out_if
);

  // Input register: one character transaction
  logic             in_valid_q;
  logic [CharW-1:0] in_char_q;
  logic             in_last_q;

  // Result register
  logic             out_valid_q;
  logic [HalfW-1:0] out_high_q;
  logic [HalfW-1:0] out_low_q;
  logic             out_bad_q;

  logic             out_free;
  logic             advance;
  logic             in_fire;
  logic             load;

  group_t           groups [NumGroups];
  parse_sum_t       sum;
  logic [HalfW-1:0] addr_high;
  logic [HalfW-1:0] addr_low;
  logic             malformed;

  // A non-final character only touches parse state, so it always moves on;
  // the final one needs room in the result register.
  assign out_free    = !out_valid_q || out_if.ready;
  assign advance     = in_valid_q && (!in_last_q || out_free);
  assign in_if.ready = !in_valid_q || advance;
  assign in_fire     = in_if.valid && in_if.ready;
  assign load        = advance && in_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_char_q <= in_if.char_code;
      in_last_q <= in_if.last_char;
    end
  end

  ipv6p_state u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .char_i  (in_char_q),
    .last_i  (in_last_q),
    .groups_o(groups),
    .sum_o   (sum)
  );

  ipv6p_assemble u_assemble (
    .groups_i   (groups),
    .sum_i      (sum),
    .addr_high_o(addr_high),
    .addr_low_o (addr_low),
    .malformed_o(malformed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_high_q <= addr_high;
      out_low_q  <= addr_low;
      out_bad_q  <= malformed;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.addr_high = out_high_q;
  assign out_if.addr_low  = out_low_q;
  assign out_if.malformed = out_bad_q;

`ifndef SYNTHESIS
  // a malformed address is reported as all zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_high_q == '0 && out_low_q == '0))
    else $error("malformed result carries a nonzero address");

  // the input register only stalls behind a final character and a full result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !in_if.ready) |-> (in_last_q && out_valid_q && !out_if.ready))
    else $error("input register stalled without cause");

  // the group count never passes the number of groups in an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |-> (sum.count <= CountW'(NumGroups)))
    else $error("group count overflow");

  // a finished address always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("final character produced no result");
`endif

endmodule

`default_nettype wire

>>> rtl/ipv6p_state.sv
// Parse state of the IPv6 text address parser: group store, counters and flags,
// with the per-character update. Depends on ipv6p_pkg.
`default_nettype none

module ipv6p_state
  import ipv6p_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [CharW-1:0] char_i,
  input  wire logic             last_i,
  output group_t                groups_o [NumGroups],
  output parse_sum_t            sum_o
);

  group_t             gs_q [NumGroups];
  logic [CountW-1:0]  gc_q, gc_d;
  logic [CountW-1:0]  sp_q, sp_d;
  logic               cs_q, cs_d;
  group_t             acc_q, acc_d;
  logic [DigitW-1:0]  dig_q, dig_d;
  logic               pc_q, pc_d;
  logic               err_q, err_d;

  hex_t               hex;
  logic               is_colon;
  logic               push_req;
  logic               wr_en;
  logic [IdxW-1:0]    wr_idx;
  group_t             wr_val;

  assign hex      = hex_decode(char_i);
  assign is_colon = (char_i == ChColon);

  always_comb begin
    gc_d     = gc_q;
    sp_d     = sp_q;
    cs_d     = cs_q;
    acc_d    = acc_q;
    dig_d    = dig_q;
    pc_d     = pc_q;
    err_d    = err_q;
    push_req = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = gc_q[IdxW-1:0];

    if (hex.ok) begin
      // a lone leading colon cannot open a group
      if (pc_q && !cs_q && gc_q == '0) begin
        err_d = 1'b1;
      end
      acc_d = {acc_q[GroupW-NibW-1:0], hex.nib};
      if (dig_q != DigitMax) begin
        dig_d = dig_q + DigitW'(1);
      end
      pc_d = 1'b0;
    end else if (is_colon) begin
      if (pc_q) begin
        if (cs_q) begin
          err_d = 1'b1;
        end else begin
          cs_d = 1'b1;
          sp_d = gc_q;
        end
      end else if (dig_q != '0) begin
        push_req = 1'b1;
      end
      pc_d = 1'b1;
    end else begin
      err_d = 1'b1;
      pc_d  = 1'b0;
    end

    if (last_i && !pc_d && dig_d != '0) begin
      push_req = 1'b1;
    end

    wr_val = acc_d;
    if (push_req) begin
      if (gc_q >= CountW'(NumGroups)) begin
        err_d = 1'b1;
      end else begin
        wr_en = 1'b1;
        gc_d  = gc_q + CountW'(1);
      end
      acc_d = '0;
      dig_d = '0;
    end

    // trailing colon only closes a "::"
    if (last_i && pc_d && !(cs_d && sp_d == gc_d)) begin
      err_d = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < NumGroups; i++) begin
      groups_o[i] = (wr_en && wr_idx == IdxW'(i)) ? wr_val : gs_q[i];
    end
  end

  assign sum_o = '{count: gc_d, split: sp_d, compressed: cs_d, error: err_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gc_q  <= '0;
      sp_q  <= '0;
      cs_q  <= 1'b0;
      acc_q <= '0;
      dig_q <= '0;
      pc_q  <= 1'b0;
      err_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        gc_q  <= '0;
        sp_q  <= '0;
        cs_q  <= 1'b0;
        acc_q <= '0;
        dig_q <= '0;
        pc_q  <= 1'b0;
        err_q <= 1'b0;
      end else begin
        gc_q  <= gc_d;
        sp_q  <= sp_d;
        cs_q  <= cs_d;
        acc_q <= acc_d;
        dig_q <= dig_d;
        pc_q  <= pc_d;
        err_q <= err_d;
      end
    end
  end

  // entries at or above the count are never read, so the store needs no reset
  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      gs_q[wr_idx] <= wr_val;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ipv6p_assemble.sv
// Address builder of the IPv6 text address parser: places stored groups around
// the "::" gap and packs the two 64-bit halves. Depends on ipv6p_pkg.
`default_nettype none

module ipv6p_assemble
  import ipv6p_pkg::*;
(
  input  wire group_t           groups_i [NumGroups],
  input  wire parse_sum_t       sum_i,
  output logic [HalfW-1:0]      addr_high_o,
  output logic [HalfW-1:0]      addr_low_o,
  output logic                  malformed_o
);

  logic [CountW-1:0] split;
  logic [CountW-1:0] tail;
  logic [CountW-1:0] tail_start;
  group_t            slot [NumGroups];

  assign split      = sum_i.compressed ? sum_i.split : sum_i.count;
  assign tail       = sum_i.count - split;
  assign tail_start = CountW'(NumGroups) - tail;

  always_comb begin
    for (int p = 0; p < NumGroups; p++) begin
      slot[p] = '0;
      if (CountW'(p) < split) begin
        slot[p] = groups_i[p];
      end else if (sum_i.compressed && CountW'(p) >= tail_start) begin
        // tail group index is p + count - 8, modulo the store depth
        slot[p] = groups_i[IdxW'(p) + sum_i.count[IdxW-1:0]];
      end
      if (sum_i.error) begin
        slot[p] = '0;
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NumGroups / 2; p++) begin
      addr_high_o[HalfW-1-p*GroupW -: GroupW] = slot[p];
      addr_low_o[HalfW-1-p*GroupW -: GroupW]  = slot[p + NumGroups / 2];
    end
  end

  assign malformed_o = sum_i.error;

endmodule

`default_nettype wire
